// ===== sv/modbus_rtu_request_framer_assert.svh =====
// assertion macros for the modbus rtu request framer
`ifndef MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH

// condition holds in the same cycle
`define MBRF_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies a condition in the next cycle
`define MBRF_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== sv/mbrf_pkg.sv =====
package mbrf_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_BAD    = 2'd3
  } kind_t;

  localparam logic [7:0] FC_READ   = 8'h03;
  localparam logic [7:0] FC_SINGLE = 8'h06;
  localparam logic [7:0] FC_DOUBLE = 8'h10;

  localparam logic [7:0] QTY_HI    = 8'h00;
  localparam logic [7:0] QTY_LO    = 8'h02;
  localparam logic [7:0] BYTE_CNT  = 8'h04;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // position of the crc low byte in short and long frames
  localparam logic [3:0] POS_CRC_SHORT = 4'd6;
  localparam logic [3:0] POS_CRC_LONG  = 4'd11;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } frm_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } frm_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last_pos;
  } frm_status_t;

  // one byte through the reflected crc-16/modbus shift
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/mbrf_req_if.sv =====
interface mbrf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  slave_address;
  logic [7:0]  param_group;
  logic [7:0]  param_offset;
  logic [15:0] reg_count;
  logic [31:0] write_value;

  modport source (
    output valid, kind, slave_address, param_group, param_offset, reg_count, write_value,
    input  ready
  );
  modport sink (
    input  valid, kind, slave_address, param_group, param_offset, reg_count, write_value,
    output ready
  );
endinterface

// ===== sv/mbrf_frame_if.sv =====
interface mbrf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// ===== sv/mbrf_datapath.sv =====
module mbrf_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mbrf_pkg::frm_cmd_t    cmd,
  output mbrf_pkg::frm_status_t status,
  input  logic [1:0]            in_kind,
  input  logic [7:0]            in_slave_address,
  input  logic [7:0]            in_param_group,
  input  logic [7:0]            in_param_offset,
  input  logic [15:0]           in_reg_count,
  input  logic [31:0]           in_write_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_frame_byte,
  output logic                  out_last_byte
);

  logic [1:0]  kind_r;
  logic [7:0]  slave_r, group_r, offset_r;
  logic [31:0] payload_r, payload_nxt;
  logic [3:0]  pos_r;
  logic [15:0] crc_r;
  logic        ovalid_r;
  logic [7:0]  obyte_r;
  logic        olast_r;

  logic [3:0]  crc_pos;
  logic [7:0]  cur_byte;
  logic        cur_last;
  logic        cur_data;

  always_comb begin
    unique case (mbrf_pkg::kind_t'(in_kind))
      mbrf_pkg::KIND_READ:   payload_nxt = {16'h0000, in_reg_count};
      mbrf_pkg::KIND_SINGLE: payload_nxt = {16'h0000, in_write_value[15:0]};
      default:               payload_nxt = in_write_value;
    endcase
  end

  assign crc_pos = (kind_r == mbrf_pkg::KIND_DOUBLE) ? mbrf_pkg::POS_CRC_LONG
                                                     : mbrf_pkg::POS_CRC_SHORT;
  assign cur_data = pos_r < crc_pos;
  assign cur_last = pos_r == (crc_pos + 4'd1);

  always_comb begin
    cur_byte = 8'h00;
    if (pos_r == crc_pos) begin
      cur_byte = crc_r[7:0];
    end else if (cur_last) begin
      cur_byte = crc_r[15:8];
    end else begin
      unique case (pos_r)
        4'd0: cur_byte = slave_r;
        4'd1: begin
          unique case (mbrf_pkg::kind_t'(kind_r))
            mbrf_pkg::KIND_READ:   cur_byte = mbrf_pkg::FC_READ;
            mbrf_pkg::KIND_SINGLE: cur_byte = mbrf_pkg::FC_SINGLE;
            default:               cur_byte = mbrf_pkg::FC_DOUBLE;
          endcase
        end
        4'd2: cur_byte = group_r;
        4'd3: cur_byte = offset_r;
        4'd4: cur_byte = (kind_r == mbrf_pkg::KIND_DOUBLE) ? mbrf_pkg::QTY_HI : payload_r[15:8];
        4'd5: cur_byte = (kind_r == mbrf_pkg::KIND_DOUBLE) ? mbrf_pkg::QTY_LO : payload_r[7:0];
        4'd6: cur_byte = mbrf_pkg::BYTE_CNT;
        4'd7: cur_byte = payload_r[15:8];
        4'd8: cur_byte = payload_r[7:0];
        4'd9: cur_byte = payload_r[23:16];
        4'd10: cur_byte = payload_r[31:24];
        default: cur_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      slave_r   <= in_slave_address;
      group_r   <= in_param_group;
      offset_r  <= in_param_offset;
      payload_r <= payload_nxt;
    end
    if (cmd.emit) begin
      obyte_r <= cur_byte;
      olast_r <= cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 4'd0;
      crc_r    <= mbrf_pkg::CRC_INIT;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pos_r <= 4'd0;
        crc_r <= mbrf_pkg::CRC_INIT;
      end else if (cmd.emit) begin
        pos_r <= pos_r + 4'd1;
        if (cur_data) begin
          crc_r <= mbrf_pkg::crc_feed(crc_r, cur_byte);
        end
      end
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign status.slot_free = !ovalid_r || out_ready;
  assign status.last_pos  = cur_last;

  assign out_valid      = ovalid_r;
  assign out_frame_byte = obyte_r;
  assign out_last_byte  = olast_r;

endmodule

// ===== sv/mbrf_ctrl.sv =====
module mbrf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_kind,
  output logic                  in_ready,
  input  mbrf_pkg::frm_status_t status,
  output mbrf_pkg::frm_cmd_t    cmd
);

  mbrf_pkg::frm_state_t state_r, state_nxt;
  logic start;

  assign start = in_valid && (in_kind != mbrf_pkg::KIND_BAD);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mbrf_pkg::ST_IDLE: begin
        if (start) state_nxt = mbrf_pkg::ST_SEND;
      end
      mbrf_pkg::ST_SEND: begin
        if (status.slot_free && status.last_pos) state_nxt = mbrf_pkg::ST_IDLE;
      end
      default: state_nxt = mbrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      mbrf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = start;
      end
      mbrf_pkg::ST_SEND: begin
        cmd.emit = status.slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/modbus_rtu_request_framer.sv =====
// modbus rtu request framer: each accepted request beat becomes one rtu frame, sent one
// byte per output beat, crc-16/modbus low byte then high byte at the end, last_byte set on
// the crc high byte. read and single write give 8 bytes, double write gives 13. a request
// is accepted in the idle state and its bytes then go out one by one while the sink keeps
// up; the byte sequencer emits at most one byte per cycle into the output register and a
// new request is taken only once the frame's last byte has entered that register. a
// request with kind 3 is accepted and dropped, with no output.
`include "modbus_rtu_request_framer_assert.svh"

module modbus_rtu_request_framer (
  input logic         clk,
  input logic         rst_n,
  mbrf_req_if.sink    in_ch,
  mbrf_frame_if.source out_ch
);

  // command and status between sequencer and datapath
  mbrf_pkg::frm_cmd_t    cmd;
  mbrf_pkg::frm_status_t status;

  // sequencer: idle waits for a request, send walks the frame bytes
  mbrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: held request, byte position, running crc, output register
  mbrf_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (in_ch.kind),
    .in_slave_address (in_ch.slave_address),
    .in_param_group   (in_ch.param_group),
    .in_param_offset  (in_ch.param_offset),
    .in_reg_count     (in_ch.reg_count),
    .in_write_value   (in_ch.write_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_frame_byte   (out_ch.frame_byte),
    .out_last_byte    (out_ch.last_byte)
  );

  // a started frame blocks new requests until its last byte is emitted
  `MBRF_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ch.ready, "request taken mid frame")
  // loading and emitting are separate phases
  `MBRF_ASSERT_NOW(a_load_emit_excl, !(cmd.load && cmd.emit), "load and emit together")
  // a byte is emitted only into a free output slot
  `MBRF_ASSERT_NOW(a_emit_slot, !cmd.emit || !out_ch.valid || out_ch.ready,
                   "emit overwrites a pending beat")
  // every emit shows a valid beat next cycle
  `MBRF_ASSERT_NEXT(a_emit_valid, cmd.emit, out_ch.valid, "emitted byte not presented")

endmodule

// ===== bench/mbrf_frame_checker.sv =====
`timescale 1ns / 100ps

module mbrf_frame_checker (
  input  logic  clk,
  input  logic  rst_n,
  mbrf_req_if   req_mon,
  mbrf_frame_if frm_mon,
  output int    fail_count,
  output int    pending_beats
);

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  frame_beat_t expected_beats[$];
  int mismatches = 0;
  int queued = 0;
  int beat_index = 0;

  assign fail_count    = mismatches;
  assign pending_beats = queued;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // one predicted beat at the tail of the expected list
  task automatic add_beat(input logic [7:0] b, input logic last);
    frame_beat_t beat;
    beat.frame_byte = b;
    beat.last_byte  = last;
    expected_beats.insert(expected_beats.size(), beat);
  endtask

  // reflected crc-16/modbus, one byte in
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    repeat (8) acc = acc[0] ? ((acc >> 1) ^ mbrf_pkg::CRC_POLY) : (acc >> 1);
    return acc;
  endfunction

  // queue the whole rtu frame that one request turns into
  task automatic predict_frame(input mbrf_pkg::kind_t kind, input logic [7:0] slave,
                               input logic [7:0] group, input logic [7:0] offset,
                               input logic [15:0] count, input logic [31:0] value);
    logic [7:0]  body[$];
    logic [15:0] crc;
    logic [7:0]  code;
    if (kind == mbrf_pkg::KIND_BAD) return;
    code = (kind == mbrf_pkg::KIND_READ)   ? mbrf_pkg::FC_READ :
           (kind == mbrf_pkg::KIND_SINGLE) ? mbrf_pkg::FC_SINGLE : mbrf_pkg::FC_DOUBLE;
    body.insert(body.size(), slave);
    body.insert(body.size(), code);
    body.insert(body.size(), group);
    body.insert(body.size(), offset);
    case (kind)
      mbrf_pkg::KIND_READ: begin
        body.insert(body.size(), count[15:8]);
        body.insert(body.size(), count[7:0]);
      end
      mbrf_pkg::KIND_SINGLE: begin
        body.insert(body.size(), value[15:8]);
        body.insert(body.size(), value[7:0]);
      end
      default: begin
        body.insert(body.size(), mbrf_pkg::QTY_HI);
        body.insert(body.size(), mbrf_pkg::QTY_LO);
        body.insert(body.size(), mbrf_pkg::BYTE_CNT);
        body.insert(body.size(), value[15:8]);
        body.insert(body.size(), value[7:0]);
        body.insert(body.size(), value[23:16]);
        body.insert(body.size(), value[31:24]);
      end
    endcase
    crc = mbrf_pkg::CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_step(crc, body[i]);
      add_beat(body[i], 1'b0);
    end
    add_beat(crc[7:0], 1'b0);
    add_beat(crc[15:8], 1'b1);
  endtask

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst_n) begin
      expected_beats.delete();
      queued <= 0;
    end else begin
      // results first, a beat never belongs to a request taken at the same edge
      if (frm_mon.valid && frm_mon.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("beat %0d unexpected, byte %02h last %0b",
                                    beat_index, frm_mon.frame_byte, frm_mon.last_byte));
        end else begin
          want = expected_beats.pop_front();
          if (frm_mon.frame_byte !== want.frame_byte)
            report_mismatch($sformatf("beat %0d frame_byte %02h, want %02h",
                                      beat_index, frm_mon.frame_byte, want.frame_byte));
          if (frm_mon.last_byte !== want.last_byte)
            report_mismatch($sformatf("beat %0d last_byte %0b, want %0b",
                                      beat_index, frm_mon.last_byte, want.last_byte));
        end
        beat_index++;
      end
      if (req_mon.valid && req_mon.ready)
        predict_frame(mbrf_pkg::kind_t'(req_mon.kind), req_mon.slave_address,
                      req_mon.param_group, req_mon.param_offset, req_mon.reg_count,
                      req_mon.write_value);
      queued <= expected_beats.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import mbrf_pkg::*;

  // number of random well-formed requests, bad kinds not counted
  localparam int RANDOM_REQUESTS = 330;
  // quiet tail of the run with no idling on either side
  localparam int QUIET_TAIL = 60;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b0;
  int   fail_count;
  int   pending_beats;

  mbrf_req_if   req_ch ();
  mbrf_frame_if frm_ch ();

  modbus_rtu_request_framer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (frm_ch)
  );

  // watches both channels, predicts every frame and compares beat by beat
  mbrf_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_ch),
    .frm_mon       (frm_ch),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  always #2 clk = ~clk;

  // mostly random field values, with all zeros and all ones showing up often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one request beat, with an optional idle burst in front of it
  // valid stays high on exit so back-to-back requests need no second assignment
  task automatic send_request(input kind_t kind, input logic [7:0] slave,
                              input logic [7:0] group, input logic [7:0] offset,
                              input logic [15:0] count, input logic [31:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= kind;
    req_ch.slave_address <= slave;
    req_ch.param_group   <= group;
    req_ch.param_offset  <= offset;
    req_ch.reg_count     <= count;
    req_ch.write_value   <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // hold the sender off until every predicted beat has come out
  task automatic drain_frames();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  // frame side: ready drops in bursts while idling is on
  initial begin : frame_sink
    int stall_left;
    frm_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        frm_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        frm_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        frm_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int    n_sent;
    bit    paused;
    kind_t kind;
    rst_n                <= 1'b0;
    req_ch.valid         <= 1'b0;
    req_ch.kind          <= KIND_READ;
    req_ch.slave_address <= '0;
    req_ch.param_group   <= '0;
    req_ch.param_offset  <= '0;
    req_ch.reg_count     <= '0;
    req_ch.write_value   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_on <= 1'b1;

    // directed: field extremes for every kind
    send_request(KIND_READ,   8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(KIND_READ,   8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(KIND_READ,   8'h01, 8'h03, 8'h05, 16'h0001, 32'h5A5A_A5A5);
    send_request(KIND_SINGLE, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(KIND_SINGLE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    // single write ignores the count and the upper value half, both give one frame
    send_request(KIND_SINGLE, 8'h11, 8'h22, 8'h33, 16'hABCD, 32'hDEAD_BEEF);
    send_request(KIND_SINGLE, 8'h11, 8'h22, 8'h33, 16'h0000, 32'h0000_BEEF);
    send_request(KIND_DOUBLE, 8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(KIND_DOUBLE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    // byte order of the double write value is 15:8, 7:0, 23:16, 31:24
    send_request(KIND_DOUBLE, 8'h7F, 8'h80, 8'h01, 16'hFFFF, 32'h1234_5678);
    // undefined kind is swallowed without a frame, alone and back to back
    send_request(KIND_BAD,    8'hAA, 8'h55, 8'hAA, 16'h5555, 32'hAAAA_AAAA);
    send_request(KIND_READ,   8'h55, 8'hAA, 8'h55, 16'hAAAA, 32'h5555_5555);
    send_request(KIND_BAD,    8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(KIND_BAD,    8'h00, 8'h00, 8'h00, 16'h0000, 32'h0000_0000);
    send_request(KIND_DOUBLE, 8'h5A, 8'hA5, 8'hC3, 16'h3C3C, 32'h8000_0001);
    drain_frames();

    // random: mostly well-formed requests, a few bad kinds as noise
    n_sent = 0;
    paused = 1'b0;
    while (n_sent < RANDOM_REQUESTS) begin
      // idling in stretches, then none for the quiet tail
      idle_on <= (n_sent < RANDOM_REQUESTS - QUIET_TAIL) && ((n_sent / 40) % 3 != 2);
      if ($urandom_range(0, 19) == 0)
        kind = KIND_BAD;
      else
        kind = kind_t'($urandom_range(0, 2));
      send_request(kind, pick_byte(), pick_byte(), pick_byte(),
                   {pick_byte(), pick_byte()},
                   {pick_byte(), pick_byte(), pick_byte(), pick_byte()});
      if (kind != KIND_BAD)
        n_sent++;
      // one full pause halfway through
      if (!paused && n_sent == RANDOM_REQUESTS / 2) begin
        drain_frames();
        paused = 1'b1;
      end
    end

    drain_frames();
    // room for a stray beat after the last expected one
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== modbus_rtu_request_framer.f =====
+incdir+sv
sv/mbrf_pkg.sv
sv/mbrf_req_if.sv
sv/mbrf_frame_if.sv
sv/mbrf_datapath.sv
sv/mbrf_ctrl.sv
sv/modbus_rtu_request_framer.sv
bench/mbrf_frame_checker.sv
bench/tb_top.sv
